@@ design/lcc_pkg.sv @@
`timescale 1ns / 1ps

package lcc_pkg;

   // pixel and hue widths
   localparam int LEVEL_WIDTH = 8;
   localparam int HUE_WIDTH   = 9;
   localparam int NUMER_WIDTH = 14;
   localparam int QUO_WIDTH   = 6;
   localparam int STEP_WIDTH  = 3;
   localparam int OUT_COUNT_WIDTH = 16;

   // stream word widths
   localparam int REQ_TDATA_WIDTH = 24;
   localparam int RSP_TDATA_WIDTH = 56;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // hue constants
   localparam logic [HUE_WIDTH-1:0] HUE_FULL  = 9'd360;
   localparam logic [HUE_WIDTH-1:0] HUE_GREEN = 9'd120;
   localparam logic [HUE_WIDTH-1:0] HUE_BLUE  = 9'd240;
   localparam logic [QUO_WIDTH-1:0] QUO_MAX   = 6'd60;

   // verdict codes
   localparam logic [1:0] LIGHT_UNKNOWN = 2'd0;
   localparam logic [1:0] LIGHT_RED     = 2'd1;
   localparam logic [1:0] LIGHT_GREEN   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_SATURATION   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_VALUE        = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_PIXELS       = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DOMINANCE_TENTHS = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RED_HUE_LOW_MAX  = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RED_HUE_HIGH_MIN = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GREEN_HUE_MIN    = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GREEN_HUE_MAX    = 4'd7;

   // which channel holds the maximum
   typedef enum logic [1:0] {
      BASE_RED   = 2'd0,
      BASE_GREEN = 2'd1,
      BASE_BLUE  = 2'd2
   } hue_base_type;

   // classified pixel handed from front to back
   typedef struct packed {
      logic                   active;
      logic                   last;
      hue_base_type           base;
      logic                   neg;
      logic [LEVEL_WIDTH-1:0] denom;
      logic [NUMER_WIDTH-1:0] numer;
   } hue_job_type;

   // configuration registers
   typedef struct packed {
      logic [7:0]           min_saturation;
      logic [7:0]           min_value;
      logic [15:0]          min_pixels;
      logic [7:0]           dominance_tenths;
      logic [HUE_WIDTH-1:0] red_hue_low_max;
      logic [HUE_WIDTH-1:0] red_hue_high_min;
      logic [HUE_WIDTH-1:0] green_hue_min;
      logic [HUE_WIDTH-1:0] green_hue_max;
   } lcc_cfg_type;

   localparam lcc_cfg_type CFG_RESET = '{
      min_saturation:   8'd70,
      min_value:        8'd90,
      min_pixels:       16'd8,
      dominance_tenths: 8'd12,
      red_hue_low_max:  9'd20,
      red_hue_high_min: 9'd340,
      green_hue_min:    9'd70,
      green_hue_max:    9'd170
   };

endpackage

@@ design/light_color_classifier.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake             word
// req      in         req_tvalid/req_tready  tdata r,g,b; tlast marks last pixel
// rsp      out        rsp_tvalid/rsp_tready  tdata verdict and three counts
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// in the back end each pixel is taken from the queue, passed through the
// bit-serial hue divider, then counted.
// after the last pixel of a region come the limit products, then the verdict.
// the front takes pixels while the two-entry queue has room; a held result
// stalls only the verdict step. reset is synchronous and restores registers.

module light_color_classifier #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] red_level, [15:8] green_level, [23:16] blue_level
   input  logic [lcc_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] verdict, [17:2] red_pixels, [33:18] green_pixels,
   // [49:34] active_pixels, [55:50] zero
   output logic [lcc_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lcc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lcc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import lcc_pkg::*;

   lcc_cfg_type cfg_ff;
   lcc_cfg_type cfg_in;
   logic        push_valid;
   logic        push_ready;
   hue_job_type push_job;
   logic        pop_valid;
   logic        pop_ready;
   hue_job_type pop_job;

   assign csr_ready = 1'b1;

   // register writes, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MIN_SATURATION:   cfg_in.min_saturation   = csr_data[7:0];
            REG_MIN_VALUE:        cfg_in.min_value        = csr_data[7:0];
            REG_MIN_PIXELS:       cfg_in.min_pixels       = csr_data[15:0];
            REG_DOMINANCE_TENTHS: cfg_in.dominance_tenths = csr_data[7:0];
            REG_RED_HUE_LOW_MAX:  cfg_in.red_hue_low_max  = csr_data[HUE_WIDTH-1:0];
            REG_RED_HUE_HIGH_MIN: cfg_in.red_hue_high_min = csr_data[HUE_WIDTH-1:0];
            REG_GREEN_HUE_MIN:    cfg_in.green_hue_min    = csr_data[HUE_WIDTH-1:0];
            REG_GREEN_HUE_MAX:    cfg_in.green_hue_max    = csr_data[HUE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pixel classification front
   lcc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // decoupling queue
   lcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // hue divide, counting and verdict
   lcc_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job        (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ design/lcc_front.sv @@
`timescale 1ns / 1ps

module lcc_front (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] red_level, [15:8] green_level, [23:16] blue_level
   input  logic [lcc_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   input  logic                                 req_tlast,
   input  lcc_pkg::lcc_cfg_type                 cfg,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output lcc_pkg::hue_job_type                 push_job
);
   import lcc_pkg::*;

   logic [LEVEL_WIDTH-1:0]   r_lvl;
   logic [LEVEL_WIDTH-1:0]   g_lvl;
   logic [LEVEL_WIDTH-1:0]   b_lvl;
   logic [LEVEL_WIDTH-1:0]   mx;
   logic [LEVEL_WIDTH-1:0]   mn;
   logic [LEVEL_WIDTH-1:0]   d;
   logic [LEVEL_WIDTH-1:0]   opa;
   logic [LEVEL_WIDTH-1:0]   opc;
   logic [LEVEL_WIDTH-1:0]   mag;
   logic                     neg;
   hue_base_type             base;
   logic [2*LEVEL_WIDTH-1:0] sat_lhs;
   logic [2*LEVEL_WIDTH-1:0] sat_rhs;
   logic                     sat_ok;
   logic                     val_ok;

   assign r_lvl = req_tdata[7:0];
   assign g_lvl = req_tdata[15:8];
   assign b_lvl = req_tdata[23:16];

   // channel extremes
   always_comb begin
      mx = (r_lvl > g_lvl) ? r_lvl : g_lvl;
      mn = (r_lvl < g_lvl) ? r_lvl : g_lvl;
      if (b_lvl > mx) begin
         mx = b_lvl;
      end
      if (b_lvl < mn) begin
         mn = b_lvl;
      end
   end

   assign d = mx - mn;

   // saturation test without division: d*255/mx >= s  <=>  d*255 >= s*mx
   assign sat_lhs = {d, 8'b0} - {8'b0, d};
   assign sat_rhs = {8'b0, cfg.min_saturation} * {8'b0, mx};
   assign sat_ok  = (mx == '0) ? (cfg.min_saturation == '0) : (sat_lhs >= sat_rhs);
   assign val_ok  = (mx >= cfg.min_value);

   // hue sector and signed channel difference
   always_comb begin
      if (mx == r_lvl) begin
         base = BASE_RED;
         opa  = g_lvl;
         opc  = b_lvl;
      end else if (mx == g_lvl) begin
         base = BASE_GREEN;
         opa  = b_lvl;
         opc  = r_lvl;
      end else begin
         base = BASE_BLUE;
         opa  = r_lvl;
         opc  = g_lvl;
      end
      neg = (opa < opc);
      mag = neg ? (opc - opa) : (opa - opc);
   end

   // numerator 60*|diff| as shift and subtract
   always_comb begin
      push_job.active = sat_ok && val_ok;
      push_job.last   = req_tlast;
      push_job.base   = base;
      push_job.neg    = neg;
      push_job.denom  = d;
      push_job.numer  = NUMER_WIDTH'({mag, 6'b0}) - NUMER_WIDTH'({mag, 2'b0});
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

@@ design/lcc_queue.sv @@
`timescale 1ns / 1ps

module lcc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  lcc_pkg::hue_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output lcc_pkg::hue_job_type pop_job
);
   import lcc_pkg::*;

   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   hue_job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != COUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ design/lcc_back.sv @@
`timescale 1ns / 1ps

module lcc_back #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lcc_pkg::lcc_cfg_type                cfg,
   input  logic                                job_valid,
   output logic                                job_ready,
   input  lcc_pkg::hue_job_type                job,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] verdict, [17:2] red_pixels, [33:18] green_pixels,
   // [49:34] active_pixels, [55:50] zero
   output logic [lcc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import lcc_pkg::*;

   localparam int PROD_WIDTH = COUNT_WIDTH + 8;
   localparam int EXT_WIDTH  = COUNT_WIDTH + OUT_COUNT_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_UPD  = 5'b00100,
      ST_PROD = 5'b01000,
      ST_EMIT = 5'b10000
   } back_state_type;

   back_state_type             state_ff;
   back_state_type             state_in;
   hue_job_type                job_ff;
   hue_job_type                job_in;
   logic [NUMER_WIDTH-1:0]     rem_ff;
   logic [NUMER_WIDTH-1:0]     rem_in;
   logic [QUO_WIDTH-1:0]       quo_ff;
   logic [QUO_WIDTH-1:0]       quo_in;
   logic [STEP_WIDTH-1:0]      step_ff;
   logic [STEP_WIDTH-1:0]      step_in;
   logic [COUNT_WIDTH-1:0]     red_tally_ff;
   logic [COUNT_WIDTH-1:0]     red_tally_in;
   logic [COUNT_WIDTH-1:0]     green_tally_ff;
   logic [COUNT_WIDTH-1:0]     green_tally_in;
   logic [COUNT_WIDTH-1:0]     active_tally_ff;
   logic [COUNT_WIDTH-1:0]     active_tally_in;
   logic [PROD_WIDTH-1:0]      red_limit_ff;
   logic [PROD_WIDTH-1:0]      red_limit_in;
   logic [PROD_WIDTH-1:0]      green_limit_ff;
   logic [PROD_WIDTH-1:0]      green_limit_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_in;

   logic [NUMER_WIDTH-1:0]     trial;
   logic [HUE_WIDTH-1:0]       quo_ext;
   logic [HUE_WIDTH-1:0]       hue;
   logic                       is_red;
   logic                       is_green;
   logic                       out_free;
   logic [PROD_WIDTH-1:0]      red_wide;
   logic [PROD_WIDTH-1:0]      green_wide;
   logic [PROD_WIDTH-1:0]      red_ten;
   logic [PROD_WIDTH-1:0]      green_ten;
   logic                       red_wins;
   logic                       green_wins;
   logic [1:0]                 verdict;
   logic [EXT_WIDTH-1:0]       red_ext;
   logic [EXT_WIDTH-1:0]       green_ext;
   logic [EXT_WIDTH-1:0]       active_ext;
   logic [EXT_WIDTH-1:0]       min_ext;

   assign job_ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shifted divisor for the current quotient bit
   assign trial   = NUMER_WIDTH'(job_ff.denom) << step_ff;
   assign quo_ext = HUE_WIDTH'(quo_ff);

   // hue from sector and truncated quotient
   always_comb begin
      case (job_ff.base)
         BASE_RED: begin
            hue = (job_ff.neg && (quo_ff != '0)) ? (HUE_FULL - quo_ext) : quo_ext;
         end
         BASE_GREEN: begin
            hue = job_ff.neg ? (HUE_GREEN - quo_ext) : (HUE_GREEN + quo_ext);
         end
         BASE_BLUE: begin
            hue = job_ff.neg ? (HUE_BLUE - quo_ext) : (HUE_BLUE + quo_ext);
         end
         default: begin
            hue = '0;
         end
      endcase
      if (job_ff.denom == '0) begin
         hue = '0;
      end
   end

   assign is_red   = (hue <= cfg.red_hue_low_max) || (hue >= cfg.red_hue_high_min);
   assign is_green = (hue >= cfg.green_hue_min) && (hue <= cfg.green_hue_max);

   // verdict: mine > floor(other*t/10)  <=>  10*mine > other*t
   assign red_wide   = PROD_WIDTH'(red_tally_ff);
   assign green_wide = PROD_WIDTH'(green_tally_ff);
   assign red_ten    = (red_wide << 3) + (red_wide << 1);
   assign green_ten  = (green_wide << 3) + (green_wide << 1);
   assign red_ext    = EXT_WIDTH'(red_tally_ff);
   assign green_ext  = EXT_WIDTH'(green_tally_ff);
   assign active_ext = EXT_WIDTH'(active_tally_ff);
   assign min_ext    = EXT_WIDTH'(cfg.min_pixels);
   assign red_wins   = (red_ext >= min_ext) && (red_ten > red_limit_ff);
   assign green_wins = (green_ext >= min_ext) && (green_ten > green_limit_ff);

   always_comb begin
      if (red_wins) begin
         verdict = LIGHT_RED;
      end else if (green_wins) begin
         verdict = LIGHT_GREEN;
      end else begin
         verdict = LIGHT_UNKNOWN;
      end
   end

   // sequencer: divide, count, judge, emit
   always_comb begin
      state_in        = state_ff;
      job_in          = job_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      step_in         = step_ff;
      red_tally_in    = red_tally_ff;
      green_tally_in  = green_tally_ff;
      active_tally_in = active_tally_ff;
      red_limit_in    = red_limit_ff;
      green_limit_in  = green_limit_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               rem_in   = job.numer;
               quo_in   = '0;
               step_in  = STEP_WIDTH'(QUO_WIDTH - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= trial) begin
               rem_in          = rem_ff - trial;
               quo_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               state_in = ST_UPD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_UPD: begin
            if (job_ff.active) begin
               if (active_tally_ff != '1) begin
                  active_tally_in = active_tally_ff + COUNT_WIDTH'(1);
               end
               if (is_red) begin
                  if (red_tally_ff != '1) begin
                     red_tally_in = red_tally_ff + COUNT_WIDTH'(1);
                  end
               end else if (is_green) begin
                  if (green_tally_ff != '1) begin
                     green_tally_in = green_tally_ff + COUNT_WIDTH'(1);
                  end
               end
            end
            state_in = job_ff.last ? ST_PROD : ST_IDLE;
         end
         ST_PROD: begin
            red_limit_in   = PROD_WIDTH'(green_tally_ff) * PROD_WIDTH'(cfg.dominance_tenths);
            green_limit_in = PROD_WIDTH'(red_tally_ff) * PROD_WIDTH'(cfg.dominance_tenths);
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = {6'b0, active_ext[OUT_COUNT_WIDTH-1:0],
                                  green_ext[OUT_COUNT_WIDTH-1:0],
                                  red_ext[OUT_COUNT_WIDTH-1:0], verdict};
               red_tally_in    = '0;
               green_tally_in  = '0;
               active_tally_in = '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         red_tally_ff    <= '0;
         green_tally_ff  <= '0;
         active_tally_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         red_tally_ff    <= red_tally_in;
         green_tally_ff  <= green_tally_in;
         active_tally_ff <= active_tally_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      step_ff        <= step_in;
      red_limit_ff   <= red_limit_in;
      green_limit_ff <= green_limit_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // divider ends with a quotient in range and a remainder below the divisor
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && job_ff.denom != '0) |-> (quo_ff <= QUO_MAX))
      else $error("hue quotient out of range");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && job_ff.denom != '0) |-> (rem_ff < NUMER_WIDTH'(job_ff.denom)))
      else $error("divider remainder not below divisor");

   // colour counts never pass the active count
   a_tally_order: assert property (@(posedge clock) disable iff (reset)
      (red_tally_ff <= active_tally_ff) && (green_tally_ff <= active_tally_ff))
      else $error("colour tally above active tally");

   // counts restart after a region verdict is loaded
   a_tally_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (active_tally_ff == '0 && rsp_valid_ff))
      else $error("tallies not cleared after verdict");

endmodule

@@ dv/tb_light_color_classifier.sv @@
`timescale 1ns / 1ps

module tb_light_color_classifier;
   import lcc_pkg::*;

   localparam int TALLY_WIDTH = 16;
   localparam int PHASE_ITEMS = 34;
   localparam int NUM_PHASES = 9;
   // queue of two plus the back end, with margin
   localparam int SETTLE_CYCLES = 40;
   localparam longint TIMEOUT_NS = 2_000_000;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED_LOW = REG_GREEN_HUE_MAX + 4'd1;

   typedef struct packed {
      logic [1:0]             state;
      logic [TALLY_WIDTH-1:0] red_total;
      logic [TALLY_WIDTH-1:0] green_total;
      logic [TALLY_WIDTH-1:0] active_total;
   } verdict_type;

   typedef struct packed {
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic        last;
      logic        typed;
      verdict_type want;
   } pixel_row_type;

   typedef enum int {
      KIND_ANY,
      KIND_RED,
      KIND_GREEN,
      KIND_GREY,
      KIND_RAIL
   } pixel_kind_type;

   // directed regions, checked by hand where the answer is obvious
   localparam int NUM_ROWS = 24;
   localparam pixel_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // black and white never count
      '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '{LIGHT_UNKNOWN, 16'd0, 16'd0, 16'd0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, '{LIGHT_UNKNOWN, 16'd0, 16'd0, 16'd0}},
      // pure primaries, one pixel is below the pixel minimum
      '{8'd255, 8'd0, 8'd0, 1'b1, 1'b1, '{LIGHT_UNKNOWN, 16'd1, 16'd0, 16'd1}},
      '{8'd0, 8'd255, 8'd0, 1'b1, 1'b1, '{LIGHT_UNKNOWN, 16'd0, 16'd1, 16'd1}},
      '{8'd0, 8'd0, 8'd255, 1'b1, 1'b1, '{LIGHT_UNKNOWN, 16'd0, 16'd0, 16'd1}},
      // ties for the largest channel
      '{8'd255, 8'd255, 8'd0, 1'b1, 1'b0, '0},
      '{8'd0, 8'd255, 8'd255, 1'b1, 1'b0, '0},
      '{8'd255, 8'd0, 8'd255, 1'b1, 1'b0, '0},
      // negative hue term wraps around
      '{8'd255, 8'd0, 8'd10, 1'b1, 1'b0, '0},
      // value threshold edge
      '{8'd89, 8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{8'd90, 8'd0, 8'd0, 1'b1, 1'b0, '0},
      // saturation threshold edge
      '{8'd255, 8'd186, 8'd186, 1'b0, 1'b0, '0},
      '{8'd255, 8'd185, 8'd185, 1'b1, 1'b0, '0},
      // red hue bounds, 20/21 and 340/339
      '{8'd255, 8'd85, 8'd0, 1'b1, 1'b0, '0},
      '{8'd255, 8'd90, 8'd0, 1'b1, 1'b0, '0},
      '{8'd255, 8'd0, 8'd85, 1'b1, 1'b0, '0},
      '{8'd255, 8'd0, 8'd90, 1'b1, 1'b0, '0},
      // green band bounds, 69/70 and 170/171
      '{8'd217, 8'd255, 8'd0, 1'b1, 1'b0, '0},
      '{8'd213, 8'd255, 8'd0, 1'b1, 1'b0, '0},
      '{8'd0, 8'd255, 8'd213, 1'b1, 1'b0, '0},
      '{8'd0, 8'd255, 8'd217, 1'b1, 1'b0, '0},
      // nearly black
      '{8'd1, 8'd0, 8'd0, 1'b1, 1'b0, '0},
      // two-pixel region, one of each color
      '{8'd255, 8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{8'd0, 8'd255, 8'd0, 1'b1, 1'b0, '0}
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_TDATA_WIDTH-1:0]  req_tdata = '0;
   logic                        req_tlast = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0]  rsp_tdata;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data = '0;

   // shadow of the block: registers and region tallies
   lcc_cfg_type            active_cfg;
   logic [TALLY_WIDTH-1:0] red_seen;
   logic [TALLY_WIDTH-1:0] green_seen;
   logic [TALLY_WIDTH-1:0] active_seen;
   // newest at the front, oldest taken from the back
   verdict_type            pending_verdicts[$];

   int mismatches = 0;
   int burst_left = 0;
   bit steady = 1'b0;

   // receiver stall pattern
   int unsigned ready_period = 1;
   int unsigned ready_low = 0;
   int unsigned ready_phase = 0;
   int unsigned ready_epoch = 0;

   light_color_classifier #(
      .COUNT_WIDTH(TALLY_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      mismatches++;
   endtask

   // saturating tally step
   function automatic logic [TALLY_WIDTH-1:0] bump(input logic [TALLY_WIDTH-1:0] t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   // count wins if it reaches the minimum and beats floor(other * tenths / 10)
   function automatic bit beats(input logic [TALLY_WIDTH-1:0] mine,
                                input logic [TALLY_WIDTH-1:0] other);
      longint unsigned cap;
      cap = (64'(other) * 64'(active_cfg.dominance_tenths)) / 64'd10;
      return (mine >= active_cfg.min_pixels) && (64'(mine) > cap);
   endfunction

   // convert to hsv, classify and count one pixel; returns 1 when a verdict is due
   function automatic bit count_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic last,
                                      output verdict_type v);
      int ri, gi, bi, hi, lo, span, hue, sat;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      hi = (ri > gi) ? ri : gi;
      lo = (ri < gi) ? ri : gi;
      if (bi > hi) hi = bi;
      if (bi < lo) lo = bi;
      span = hi - lo;
      sat = (hi == 0) ? 0 : (span * 255) / hi;
      // signed division truncates toward zero
      if (span == 0) hue = 0;
      else if (hi == ri) hue = (60 * (gi - bi) / span + 360) % 360;
      else if (hi == gi) hue = 60 * (bi - ri) / span + 120;
      else hue = 60 * (ri - gi) / span + 240;
      v = '0;
      if (sat >= int'(active_cfg.min_saturation) && hi >= int'(active_cfg.min_value)) begin
         active_seen = bump(active_seen);
         if (hue <= int'(active_cfg.red_hue_low_max) ||
             hue >= int'(active_cfg.red_hue_high_min)) begin
            red_seen = bump(red_seen);
         end else if (hue >= int'(active_cfg.green_hue_min) &&
                      hue <= int'(active_cfg.green_hue_max)) begin
            green_seen = bump(green_seen);
         end
      end
      if (!last) return 1'b0;
      if (beats(red_seen, green_seen)) v.state = LIGHT_RED;
      else if (beats(green_seen, red_seen)) v.state = LIGHT_GREEN;
      else v.state = LIGHT_UNKNOWN;
      v.red_total = red_seen;
      v.green_total = green_seen;
      v.active_total = active_seen;
      red_seen = '0;
      green_seen = '0;
      active_seen = '0;
      return 1'b1;
   endfunction

   // hold the sender until every verdict is back, then let the back end settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // bursts with random gaps, occasionally a full drain
   task automatic pace();
      int gap;
      if (steady) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 49) == 0) begin
         drain();
      end else if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left = $urandom_range(0, 15);
   endtask

   // send one pixel word and record its verdict once accepted
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic last, input logic typed, input verdict_type want);
      verdict_type v;
      req_tvalid <= 1'b1;
      req_tdata <= {b, g, r};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      if (count_pixel(r, g, b, last, v)) pending_verdicts.push_front(typed ? want : v);
      pace();
   endtask

   // single register write, leaves csr_valid high for back-to-back writes
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_MIN_SATURATION:   active_cfg.min_saturation = data[7:0];
         REG_MIN_VALUE:        active_cfg.min_value = data[7:0];
         REG_MIN_PIXELS:       active_cfg.min_pixels = data;
         REG_DOMINANCE_TENTHS: active_cfg.dominance_tenths = data[7:0];
         REG_RED_HUE_LOW_MAX:  active_cfg.red_hue_low_max = data[HUE_WIDTH-1:0];
         REG_RED_HUE_HIGH_MIN: active_cfg.red_hue_high_min = data[HUE_WIDTH-1:0];
         REG_GREEN_HUE_MIN:    active_cfg.green_hue_min = data[HUE_WIDTH-1:0];
         REG_GREEN_HUE_MAX:    active_cfg.green_hue_max = data[HUE_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // program a full register set, junk in the unused upper bits and one dead index
   task automatic write_all(input lcc_cfg_type c);
      write_reg(REG_UNUSED_LOW + 4'($urandom_range(0, 7)), 16'($urandom));
      write_reg(REG_MIN_SATURATION, {8'($urandom), c.min_saturation});
      write_reg(REG_MIN_VALUE, {8'($urandom), c.min_value});
      write_reg(REG_MIN_PIXELS, c.min_pixels);
      write_reg(REG_DOMINANCE_TENTHS, {8'($urandom), c.dominance_tenths});
      write_reg(REG_RED_HUE_LOW_MAX, {7'($urandom), c.red_hue_low_max});
      write_reg(REG_RED_HUE_HIGH_MIN, {7'($urandom), c.red_hue_high_min});
      write_reg(REG_GREEN_HUE_MIN, {7'($urandom), c.green_hue_min});
      write_reg(REG_GREEN_HUE_MAX, {7'($urandom), c.green_hue_max});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly plausible thresholds, sometimes anything the widths allow
   function automatic lcc_cfg_type random_config();
      lcc_cfg_type c;
      bit wide;
      wide = ($urandom_range(0, 3) == 0);
      c.min_saturation = wide ? 8'($urandom) : 8'($urandom_range(0, 120));
      c.min_value = wide ? 8'($urandom) : 8'($urandom_range(0, 150));
      c.min_pixels = wide ? 16'($urandom) : 16'($urandom_range(0, 20));
      c.dominance_tenths = wide ? 8'($urandom) : 8'($urandom_range(0, 30));
      c.red_hue_low_max = wide ? 9'($urandom) : 9'($urandom_range(0, 40));
      c.red_hue_high_min = wide ? 9'($urandom) : 9'($urandom_range(300, 359));
      c.green_hue_min = wide ? 9'($urandom) : 9'($urandom_range(60, 110));
      c.green_hue_max = wide ? 9'($urandom) : 9'($urandom_range(120, 200));
      return c;
   endfunction

   // pixel leaning toward one kind of color
   function automatic logic [23:0] random_pixel(input pixel_kind_type favored);
      pixel_kind_type kind;
      logic [7:0] r, g, b;
      kind = ($urandom_range(0, 9) < 6) ? favored : pixel_kind_type'($urandom_range(0, 4));
      case (kind)
         KIND_RED: begin
            r = 8'($urandom_range(100, 255));
            g = 8'($urandom_range(0, 90));
            b = 8'($urandom_range(0, 90));
         end
         KIND_GREEN: begin
            r = 8'($urandom_range(0, 110));
            g = 8'($urandom_range(100, 255));
            b = 8'($urandom_range(0, 200));
         end
         KIND_GREY: begin
            r = 8'($urandom);
            g = r ^ 8'($urandom_range(0, 7));
            b = r ^ 8'($urandom_range(0, 7));
         end
         KIND_RAIL: begin
            r = {8{1'($urandom)}};
            g = {8{1'($urandom)}};
            b = {8{1'($urandom)}};
         end
         default: begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
         end
      endcase
      return {b, g, r};
   endfunction

   // random regions; now and then one runs on into the next without its last flag
   task automatic run_regions(input int quota);
      int sent, len, i;
      pixel_kind_type favored;
      logic close;
      logic [23:0] px;
      sent = 0;
      while (sent < quota) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
         favored = pixel_kind_type'($urandom_range(0, 4));
         close = ($urandom_range(0, 19) != 0);
         for (i = 0; i < len; i++) begin
            px = random_pixel(favored);
            send_pixel(px[7:0], px[15:8], px[23:16], close && (i == len - 1), 1'b0, '0);
         end
         sent += len;
      end
   endtask

   // result checking and receiver stalls
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("result word with no verdict pending", rsp_tdata, 0);
         end else begin
            want = pending_verdicts.pop_back();
            if (rsp_tdata[1:0] !== want.state)
               report_mismatch("verdict", rsp_tdata[1:0], want.state);
            if (rsp_tdata[17:2] !== want.red_total)
               report_mismatch("red pixels", rsp_tdata[17:2], want.red_total);
            if (rsp_tdata[33:18] !== want.green_total)
               report_mismatch("green pixels", rsp_tdata[33:18], want.green_total);
            if (rsp_tdata[49:34] !== want.active_total)
               report_mismatch("active pixels", rsp_tdata[49:34], want.active_total);
            if (rsp_tdata[55:50] !== '0)
               report_mismatch("padding bits", rsp_tdata[55:50], 0);
         end
      end
      // new stall pattern each time the epoch runs out, some with no stalls at all
      if (ready_epoch == 0) begin
         ready_epoch = $urandom_range(50, 400);
         ready_period = $urandom_range(2, 10);
         ready_low = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, ready_period - 1);
      end else begin
         ready_epoch--;
      end
      ready_phase = (ready_phase + 1) % ready_period;
      rsp_tready <= (ready_phase >= ready_low);
   end

   // stimulus
   initial begin
      int phase, i;
      lcc_cfg_type next_cfg;
      active_cfg = CFG_RESET;
      red_seen = '0;
      green_seen = '0;
      active_seen = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed regions under reset thresholds
      for (i = 0; i < NUM_ROWS; i++) begin
         send_pixel(DIRECTED_ROWS[i].r, DIRECTED_ROWS[i].g, DIRECTED_ROWS[i].b,
                    DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
      run_regions(PHASE_ITEMS);
      drain();

      // threshold sets: extremes first, then reset values, a zero-limit set, a band set, then random
      for (phase = 1; phase <= NUM_PHASES; phase++) begin
         case (phase)
            1: next_cfg = '0;
            2: next_cfg = '1;
            3: next_cfg = CFG_RESET;
            4: begin
               next_cfg = random_config();
               next_cfg.min_pixels = '0;
               next_cfg.dominance_tenths = '0;
            end
            5: begin
               // empty green band, red only at the hue extremes
               next_cfg = CFG_RESET;
               next_cfg.green_hue_min = 9'd200;
               next_cfg.green_hue_max = 9'd100;
               next_cfg.red_hue_low_max = 9'd0;
               next_cfg.red_hue_high_min = 9'd359;
            end
            default: next_cfg = random_config();
         endcase
         write_all(next_cfg);
         steady = ($urandom_range(0, 3) == 0);
         run_regions(PHASE_ITEMS);
         drain();
      end

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
